// ----- sv/rqp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rqp_pkg;

  // Number of lanes carried through the datapath (the four-bit precision uses all of them).
  localparam int unsigned LANES     = 8;
  localparam int unsigned LANE_W    = 64;
  localparam int unsigned ACC_W     = 96;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned SHIFT_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    PREC_4  = 2'd0,
    PREC_8  = 2'd1,
    PREC_16 = 2'd2,
    PREC_32 = 2'd3
  } prec_t;

  typedef enum logic [1:0] {
    RND_EVEN = 2'd0,
    RND_ZERO = 2'd1,
    RND_PINF = 2'd2,
    RND_NINF = 2'd3
  } rnd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRECISION = 2'd0,
    CFG_ROUND     = 2'd1,
    CFG_SCALE     = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef logic [LANE_W-1:0]            lane_t;
  typedef lane_t [LANES-1:0]            lane_vec_t;

  // Static configuration; the user must keep it stable whenever items are in flight, as the block does not enforce it.
  typedef struct packed {
    prec_t              prec;
    rnd_t               rnd;
    logic [SHIFT_W-1:0] shift;
  } cfg_t;

  // After lane split.
  typedef struct packed {
    lane_vec_t lane;
    logic      wide_ovf;
    logic      wide_neg;
  } split_t;

  // After the shift: truncated value plus round and sticky bits per lane.
  typedef struct packed {
    lane_vec_t        trunc;
    logic [LANES-1:0] rbit;
    logic [LANES-1:0] sticky;
    logic [LANES-1:0] neg;
    logic             wide_ovf;
    logic             wide_neg;
  } shifted_t;

  // After rounding.
  typedef struct packed {
    lane_vec_t val;
    logic      wide_ovf;
    logic      wide_neg;
  } rounded_t;

endpackage

`default_nettype wire

// ----- sv/rqp_split.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rqp_split
  import rqp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cfg_t              cfg,
  input  wire logic              up_valid,
  output logic                   up_ready,
  input  wire logic [ACC_W-1:0]  acc,
  output logic                   dn_valid,
  input  wire logic              dn_ready,
  output split_t                 dn_data
);

  logic   vld_r, vld_nxt;
  split_t data_r, data_nxt;

  // Cut the accumulator into lanes, sign or zero extended to 64 bits.
  always_comb begin
    data_nxt = '0;
    case (cfg.prec)
      PREC_4: begin
        for (int i = 0; i < 8; i++) begin
          data_nxt.lane[i] = {52'd0, acc[12*i +: 12]};
        end
      end
      PREC_8: begin
        for (int i = 0; i < 4; i++) begin
          data_nxt.lane[i] = {{40{acc[24*i+23]}}, acc[24*i +: 24]};
        end
      end
      PREC_16: begin
        for (int i = 0; i < 2; i++) begin
          data_nxt.lane[i] = {{16{acc[48*i+47]}}, acc[48*i +: 48]};
        end
      end
      PREC_32: begin
        data_nxt.lane[0] = acc[63:0];
        data_nxt.wide_ovf = !((acc[95:64] == 32'd0) || (acc[95:64] == 32'hFFFF_FFFF));
        data_nxt.wide_neg = acc[95];
      end
      default: data_nxt = '0;
    endcase
  end

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ----- sv/rqp_shift.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rqp_shift
  import rqp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire split_t   up_data,
  output logic          dn_valid,
  input  wire logic     dn_ready,
  output shifted_t      dn_data
);

  logic               vld_r, vld_nxt;
  shifted_t           data_r, data_nxt;
  logic               right;
  logic [5:0]         rsh;
  logic [5:0]         rpos;
  logic [SHIFT_W-1:0] lsh;
  lane_t              smask;

  // A positive amount shifts right and keeps the round and sticky bits;
  // zero or negative shifts left and wraps in 64 bits.
  always_comb begin
    right = !cfg.shift[SHIFT_W-1] && (cfg.shift != '0);
    rsh   = cfg.shift[5:0];
    rpos  = rsh - 6'd1;
    lsh   = (~cfg.shift) + {{(SHIFT_W-1){1'b0}}, 1'b1};
    smask = (lane_t'(1) << rpos) - lane_t'(1);

    data_nxt          = '0;
    data_nxt.wide_ovf = up_data.wide_ovf;
    data_nxt.wide_neg = up_data.wide_neg;
    for (int i = 0; i < LANES; i++) begin
      data_nxt.neg[i] = up_data.lane[i][LANE_W-1];
      if (right) begin
        data_nxt.trunc[i]  = $signed(up_data.lane[i]) >>> rsh;
        data_nxt.rbit[i]   = up_data.lane[i][rpos];
        data_nxt.sticky[i] = |(up_data.lane[i] & smask);
      end else begin
        data_nxt.trunc[i]  = up_data.lane[i] << lsh;
        data_nxt.rbit[i]   = 1'b0;
        data_nxt.sticky[i] = 1'b0;
      end
    end
  end

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ----- sv/rqp_round.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rqp_round
  import rqp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     up_valid,
  output logic          up_ready,
  input  wire shifted_t up_data,
  output logic          dn_valid,
  input  wire logic     dn_ready,
  output rounded_t      dn_data
);

  logic             vld_r, vld_nxt;
  rounded_t         data_r, data_nxt;
  logic [LANES-1:0] inc;
  logic [LANES-1:0] lost;

  always_comb begin
    data_nxt          = '0;
    data_nxt.wide_ovf = up_data.wide_ovf;
    data_nxt.wide_neg = up_data.wide_neg;
    for (int i = 0; i < LANES; i++) begin
      lost[i] = up_data.rbit[i] || up_data.sticky[i];
      case (cfg.rnd)
        RND_EVEN: inc[i] = up_data.rbit[i] && (up_data.sticky[i] || up_data.trunc[i][0]);
        RND_ZERO: inc[i] = up_data.neg[i] && lost[i];
        RND_PINF: inc[i] = !up_data.neg[i] && lost[i];
        RND_NINF: inc[i] = 1'b0;
        default:  inc[i] = 1'b0;
      endcase
      data_nxt.val[i] = up_data.trunc[i] + {{(LANE_W-1){1'b0}}, inc[i]};
    end
  end

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ----- sv/rqp_pack.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rqp_pack
  import rqp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_t               cfg,
  input  wire logic               up_valid,
  output logic                    up_ready,
  input  wire rounded_t           up_data,
  output logic                    dn_valid,
  input  wire logic               dn_ready,
  output logic [WORD_W-1:0]       dn_word
);

  logic              vld_r, vld_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;

  function automatic logic [3:0] sat_u4(lane_t v);
    logic [3:0] r;
    if (v[LANE_W-1]) begin
      r = 4'd0;
    end else if (v[LANE_W-2:4] != '0) begin
      r = 4'hF;
    end else begin
      r = v[3:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] sat_s8(lane_t v);
    logic [7:0] r;
    if (v[LANE_W-1:7] == {(LANE_W-7){v[LANE_W-1]}}) begin
      r = v[7:0];
    end else begin
      r = v[LANE_W-1] ? 8'h80 : 8'h7F;
    end
    return r;
  endfunction

  function automatic logic [15:0] sat_s16(lane_t v);
    logic [15:0] r;
    if (v[LANE_W-1:15] == {(LANE_W-15){v[LANE_W-1]}}) begin
      r = v[15:0];
    end else begin
      r = v[LANE_W-1] ? 16'h8000 : 16'h7FFF;
    end
    return r;
  endfunction

  function automatic logic [31:0] sat_s32(lane_t v);
    logic [31:0] r;
    if (v[LANE_W-1:31] == {(LANE_W-31){v[LANE_W-1]}}) begin
      r = v[31:0];
    end else begin
      r = v[LANE_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return r;
  endfunction

  always_comb begin
    word_nxt = '0;
    case (cfg.prec)
      PREC_4: begin
        for (int i = 0; i < 8; i++) begin
          word_nxt[4*i +: 4] = sat_u4(up_data.val[i]);
        end
      end
      PREC_8: begin
        for (int i = 0; i < 4; i++) begin
          word_nxt[8*i +: 8] = sat_s8(up_data.val[i]);
        end
      end
      PREC_16: begin
        for (int i = 0; i < 2; i++) begin
          word_nxt[16*i +: 16] = sat_s16(up_data.val[i]);
        end
      end
      PREC_32: begin
        // An accumulator whose upper 32 bits are neither all zeros nor all ones saturates without scaling.
        if (up_data.wide_ovf) begin
          word_nxt = up_data.wide_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          word_nxt = sat_s32(up_data.val[0]);
        end
      end
      default: word_nxt = '0;
    endcase
  end

  assign up_ready = !vld_r || dn_ready;
  assign vld_nxt  = up_ready ? up_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = vld_r;
  assign dn_word  = word_r;

endmodule

`default_nettype wire

// ----- sv/simd_requantize_pack_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Requantizer for a 96-bit MAC accumulator word. Each input transfer carries one
// accumulator (bits 63..0 in in_tdata[63:0], bits 95..64 in in_tdata[95:64]) and
// produces exactly one output transfer with one 32-bit packed word. The precision
// register selects eight unsigned 12-bit lanes saturated to 4 bits, four signed 24-bit
// lanes saturated to 8 bits, two signed 48-bit lanes saturated to 16 bits, or one
// 96-bit value saturated to 32 bits; lane 0 sits in the least significant bits of the
// result. Every lane is shifted by the signed shift-amount register (right with the
// selected rounding mode when positive, left with 64-bit wrap otherwise) before
// saturation. In the 32-bit mode, an accumulator whose upper 32 bits are neither all
// zeros nor all ones saturates directly by its top bit. The datapath is a four-stage
// pipeline (lane split, shift, round, saturate and pack), and one item is accepted
// every cycle as long as the output side keeps taking words. Each stage has its own
// valid bit and a ready that passes combinationally through every later stage to
// out_tready, so a stall at the output fills the bubbles first and the input stays
// open until all four stages hold data. Configuration registers are written through
// cfg_wr_en/cfg_index/cfg_wdata and must only change while the pipeline is empty; an
// index beyond the three registers is ignored.

module simd_requantize_pack_top
  import rqp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [ACC_W-1:0]     in_tdata,   // acc_low [63:0], acc_high [95:64]

  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [WORD_W-1:0]         out_tdata,  // packed_word [31:0]

  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SHIFT_W-1:0]   cfg_wdata
);

  cfg_t     cfg_r, cfg_nxt;
  logic     s1_valid, s1_ready;
  split_t   s1_data;
  logic     s2_valid, s2_ready;
  shifted_t s2_data;
  logic     s3_valid, s3_ready;
  rounded_t s3_data;

  // Register file: each write updates only the addressed register.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PRECISION: cfg_nxt.prec  = prec_t'(cfg_wdata[1:0]);
        CFG_ROUND:     cfg_nxt.rnd   = rnd_t'(cfg_wdata[1:0]);
        CFG_SCALE:     cfg_nxt.shift = cfg_wdata;
        default:       cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prec  <= PREC_8;
      cfg_r.rnd   <= RND_EVEN;
      cfg_r.shift <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stage 1: split the accumulator into lanes.
  rqp_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .acc      (in_tdata),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  // Stage 2: barrel shift and extract the round and sticky bits.
  rqp_shift u_shift (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_data),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_data  (s2_data)
  );

  // Stage 3: rounding increment.
  rqp_round u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  // Stage 4: saturate, pack and hold the output word.
  rqp_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .up_valid (s3_valid),
    .up_ready (s3_ready),
    .up_data  (s3_data),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_word  (out_tdata)
  );

endmodule

`default_nettype wire

// ----- sv/rqp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rqp_checker
  import rqp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tready,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [WORD_W-1:0] out_tdata
);

  // A word offered at the output stays until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("output word changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The input only closes when every stage is full and the output is stalled.
  a_back_pressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back-pressure");

endmodule

bind simd_requantize_pack_top rqp_checker u_rqp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ----- sim/tb_simd_requantize_pack_top.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the accumulator requantizer.
//
// Every accumulator word that the block accepts produces one packed word, so
// the bench predicts that word at the moment of the input transfer and queues
// it. The queue is drained in order by the result checker on every output
// transfer. Configuration registers only change while the pipeline is empty:
// before each new setting, the sender stops and the bench waits until every
// queued word has been seen.
//
// The stimulus opens with a short list of hand-picked words. These are the
// saturation corners of every precision, the rounding ties under all four
// rounding modes, the shift extremes, and the wide-mode overflow of the upper
// accumulator word. After that come random phases. Each phase has its own
// register setting and lane values that are steered toward the saturation
// limits and the rounding ties.

module tb_simd_requantize_pack_top;
  import rqp_pkg::*;

  localparam int TOTAL_ITEMS = 1850;
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off used to fill the pipeline
  localparam int IDLE_LIMIT  = 2000;  // cycles without any transfer before giving up
  localparam int PIPE_DEPTH  = 4;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [ACC_W-1:0]     in_tdata   = '0;   // acc_low [63:0], acc_high [95:64]
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [WORD_W-1:0]    out_tdata;         // packed_word [31:0]
  logic                 cfg_wr_en  = 1'b0;
  cfg_idx_t             cfg_index  = CFG_PRECISION;
  logic [SHIFT_W-1:0]   cfg_wdata  = '0;

  simd_requantize_pack_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // The bench keeps its own copy of the register settings. It starts at the
  // reset values.
  prec_t              cur_prec  = PREC_8;
  rnd_t               cur_rnd   = RND_EVEN;
  logic signed [6:0]  cur_shift = '0;

  logic [31:0] pending_words[$];  // predicted packed words, oldest first

  int  n_sent;
  int  n_directed;
  int  n_checked;
  int  n_errs;
  int  n_settings;
  int  n_holds;
  int  idle_cycles;
  int  burst_left;
  bit  bursty;
  bit  hold_req;

  // One row of the opening list. The packed word is filled in only where it
  // is obvious. Every other row is predicted.
  typedef struct {
    prec_t             prec;
    rnd_t              rnd;
    logic signed [6:0] shift;
    logic [95:0]       acc;
    bit                known;
    logic [31:0]       word;
  } stim_row_t;

  stim_row_t stim_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Shift one 64-bit lane by the scale amount. A positive amount is a right
  // shift with the selected rounding. Zero or a negative amount is a left
  // shift that wraps in 64 bits, and all bits are shifted out at 64.
  function automatic logic [63:0] scale_lane(logic [63:0] v);
    int          s;
    logic [63:0] dropped;
    logic [63:0] half;
    logic [63:0] q;
    logic        neg;
    logic        bump;
    s = cur_shift;
    if (s <= 0)
      return (-s >= 64) ? 64'd0 : (v << (-s));
    neg     = v[63];
    dropped = v & ((64'd1 << s) - 64'd1);
    half    = 64'd1 << (s - 1);
    q       = $signed(v) >>> s;
    case (cur_rnd)
      RND_EVEN: bump = (dropped > half) || ((dropped == half) && q[0]);
      RND_ZERO: bump = neg && (dropped != 0);
      RND_PINF: bump = !neg && (dropped != 0);
      default:  bump = 1'b0;
    endcase
    return q + 64'(bump);
  endfunction

  // Saturate a signed 64-bit value to a signed field of the given width.
  function automatic logic [31:0] clamp_signed(logic [63:0] v, int bits);
    longint val;
    longint hi_lim;
    longint lo_lim;
    val    = $signed(v);
    hi_lim = (longint'(1) << (bits - 1)) - 1;
    lo_lim = -hi_lim - 1;
    if (val > hi_lim) val = hi_lim;
    if (val < lo_lim) val = lo_lim;
    return 32'(64'(val) & ((64'd1 << bits) - 64'd1));
  endfunction

  // Predict the packed word for one accumulator under the current settings.
  function automatic logic [31:0] requant_word(logic [95:0] acc);
    logic [31:0] word;
    logic [63:0] lane;
    longint      r;
    int          i;
    word = '0;
    case (cur_prec)
      PREC_4: begin
        // The 12-bit lanes are unsigned. The result clamps to the range 0 to 15.
        for (i = 0; i < 8; i++) begin
          lane = 64'(acc[12*i +: 12]);
          r    = $signed(scale_lane(lane));
          word[4*i +: 4] = (r < 0) ? 4'd0 : ((r > 15) ? 4'd15 : 4'(r));
        end
      end
      PREC_8: begin
        for (i = 0; i < 4; i++) begin
          lane = {{40{acc[24*i+23]}}, acc[24*i +: 24]};
          word[8*i +: 8] = 8'(clamp_signed(scale_lane(lane), 8));
        end
      end
      PREC_16: begin
        for (i = 0; i < 2; i++) begin
          lane = {{16{acc[48*i+47]}}, acc[48*i +: 48]};
          word[16*i +: 16] = 16'(clamp_signed(scale_lane(lane), 16));
        end
      end
      default: begin
        // The upper word must be a pure sign pattern. Otherwise the result
        // saturates on bit 95 alone, without any scaling.
        if (acc[95:64] == '0 || acc[95:64] == '1)
          word = clamp_signed(scale_lane(acc[63:0]), 32);
        else
          word = acc[95] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    endcase
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Random lane values
  // ---------------------------------------------------------------------------

  // A lane value of width w whose output field is obits wide. Most values sit
  // near the saturation limits once scaled, some fall exactly on a rounding
  // tie, and the rest are lane corners or raw bits.
  function automatic logic [63:0] lane_value(int w, int obits);
    logic [63:0] v;
    logic [63:0] base;
    int          s;
    int          kind;
    s    = cur_shift;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      v = {$urandom, $urandom};
    end else if (kind < 4) begin
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = '1;
        2:       v = 64'd1 << (w - 1);
        default: v = (64'd1 << (w - 1)) - 64'd1;
      endcase
    end else begin
      // Take a signed value of about four times the output range, then undo the
      // scaling so that it lands there again after the shift.
      base = $signed({$urandom, $urandom}) >>> (62 - obits);
      if (s > 0) begin
        v = base << s;
        case ($urandom_range(0, 3))
          0:       v = v | (64'd1 << (s - 1));
          1:       v = v | ({$urandom, $urandom} & ((64'd1 << s) - 64'd1));
          2:       v = v | ((64'd1 << (s - 1)) + 64'd1);
          default: ;
        endcase
      end else if (s < 0 && s > -64) begin
        v = $signed(base) >>> (-s);
      end else begin
        v = base;
      end
    end
    return v;
  endfunction

  function automatic logic [95:0] gen_acc();
    logic [95:0] acc;
    logic [63:0] lane;
    int          i;
    acc = {$urandom, $urandom, $urandom};
    if ($urandom_range(0, 3) != 0) begin
      case (cur_prec)
        PREC_4:
          for (i = 0; i < 8; i++) begin
            lane = lane_value(12, 4);
            acc[12*i +: 12] = lane[11:0];
          end
        PREC_8:
          for (i = 0; i < 4; i++) begin
            lane = lane_value(24, 8);
            acc[24*i +: 24] = lane[23:0];
          end
        PREC_16:
          for (i = 0; i < 2; i++) begin
            lane = lane_value(48, 16);
            acc[48*i +: 48] = lane[47:0];
          end
        default: begin
          lane = lane_value(64, 32);
          case ($urandom_range(0, 4))
            0, 1, 2: acc = {{32{lane[63]}}, lane};
            3:       acc = {~{32{lane[63]}}, lane};
            default: acc[63:0] = lane;
          endcase
        end
      endcase
    end
    return acc;
  endfunction

  // The shift is biased toward the extremes and toward amounts that leave
  // something to round.
  function automatic logic signed [6:0] pick_shift();
    case ($urandom_range(0, 9))
      0, 1:
        case ($urandom_range(0, 5))
          0:       return 7'(-64);
          1:       return 7'(-16);
          2:       return 7'(-1);
          3:       return 7'(0);
          4:       return 7'(1);
          default: return 7'(63);
        endcase
      2, 3, 4, 5, 6: return 7'($urandom_range(1, 24));
      7:             return 7'(-int'($urandom_range(1, 16)));
      default:       return 7'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Each call starts at a rising edge. The block must be idle.
  task automatic program_regs(prec_t p, rnd_t r, logic signed [6:0] sh);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_PRECISION;
    cfg_wdata <= 7'(p);
    @(posedge clk);
    cfg_index <= CFG_ROUND;
    cfg_wdata <= 7'(r);
    @(posedge clk);
    cfg_index <= CFG_SCALE;
    cfg_wdata <= sh;
    @(posedge clk);
    // Now and then the write goes to the unused index, which must change nothing.
    if ($urandom_range(0, 3) == 0) begin
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= 7'($urandom);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cur_prec  = p;
    cur_rnd   = r;
    cur_shift = sh;
    n_settings++;
  endtask

  // Stop sending and wait until every predicted word has come out.
  task automatic settle_pipe();
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0)
      @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // Offer one accumulator and hold it until the block takes it. The sender
  // runs in bursts. Between bursts, a bursty phase leaves random gaps.
  task automatic push_acc(logic [95:0] acc, logic [31:0] word);
    int gap;
    if (burst_left == 0) begin
      gap = bursty ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= acc;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    pending_words.push_back(word);
    n_sent++;
  endtask

  function automatic void add_row(prec_t p, rnd_t r, int sh, logic [95:0] acc,
                                  bit known = 1'b0, logic [31:0] word = '0);
    stim_row_t row;
    row.prec  = p;
    row.rnd   = r;
    row.shift = 7'(sh);
    row.acc   = acc;
    row.known = known;
    row.word  = word;
    stim_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: a 16-bit ready pattern that is reloaded each time it runs out.
  // It is sometimes all ones and sometimes sparse. On request it holds off for
  // a long stretch.
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    logic [15:0] ready_bits;
    int          k;
    @(posedge clk);
    forever begin
      case ($urandom_range(0, 3))
        0:       ready_bits = '1;
        1:       ready_bits = 16'($urandom);
        2:       ready_bits = 16'($urandom | $urandom);
        default: ready_bits = 16'($urandom & $urandom);
      endcase
      for (k = 0; k < 16; k++) begin
        if (hold_req) begin
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
          hold_req = 1'b0;
          n_holds++;
        end
        out_tready <= ready_bits[k];
        @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and activity counter for the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        n_errs++;
        if (n_errs <= 10)
          $display("[%0t] packed word %h arrived with none pending", $realtime, out_tdata);
      end else begin
        want = pending_words.pop_front();
        n_checked++;
        if (out_tdata !== want) begin
          n_errs++;
          if (n_errs <= 10)
            $display("[%0t] packed word #%0d: expected %h, got %h",
                     $realtime, n_checked, want, out_tdata);
        end
      end
    end
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
  end

  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT)
      @(posedge clk);
    $display("[%0t] no transfer for %0d cycles, %0d words still pending",
             $realtime, IDLE_LIMIT, pending_words.size());
    $display("** simd_requantize_pack_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int                k;
    int                phase;
    int                count;
    prec_t             p;
    rnd_t              r;
    logic signed [6:0] sh;
    logic [95:0]       acc;

    // The first three rows run on the reset setting: eight-bit lanes, round
    // to nearest even, no shift.
    add_row(PREC_8,  RND_EVEN,   0, 96'h800000_FFFF80_000080_00007F, 1, 32'h8080_7F7F);
    add_row(PREC_8,  RND_EVEN,   0, '1, 1, 32'hFFFF_FFFF);
    add_row(PREC_8,  RND_EVEN,   0, '0, 1, 32'h0000_0000);
    // Halfway and off-halfway cases, positive and negative, under every
    // rounding mode.
    add_row(PREC_8,  RND_EVEN,   1, 96'h000005_FFFFFF_000003_000001);
    add_row(PREC_8,  RND_ZERO,   1, 96'h000005_FFFFFF_000003_000001);
    add_row(PREC_8,  RND_PINF,   1, 96'h000005_FFFFFF_000003_000001);
    add_row(PREC_8,  RND_NINF,   1, 96'h000005_FFFFFF_000003_000001);
    add_row(PREC_8,  RND_EVEN,  63, 96'h7FFFFF_800000_FFFFFF_000001);
    // At a shift of -64, every bit is shifted out of the lane.
    add_row(PREC_8,  RND_EVEN, -64, '1, 1, 32'h0000_0000);
    add_row(PREC_8,  RND_EVEN, -16, 96'h000001_000001_000001_000001, 1, 32'h7F7F_7F7F);
    // Four-bit lanes are unsigned: 0x800 counts as 2048.
    add_row(PREC_4,  RND_EVEN,   0, 96'h00F_010_FFF_000_005_800_7FF_001, 1, 32'hFFF0_5FF1);
    // A left shift that wraps into the sign bit drives a four-bit lane to zero.
    add_row(PREC_4,  RND_PINF, -52, 96'h001_800_001_800_001_800_001_800);
    add_row(PREC_4,  RND_NINF,   4, 96'h0F8_018_017_008_0FF_100_00F_ABC);
    add_row(PREC_16, RND_EVEN,   0, 96'h7FFF_FFFF_FFFF_8000_0000_0000, 1, 32'h7FFF_8000);
    add_row(PREC_16, RND_ZERO, -16, 96'h0000_0000_8000_FFFF_FFFF_7FFF);
    // In the wide mode, only a pure sign pattern in the upper word lets the
    // low 64 bits through.
    add_row(PREC_32, RND_EVEN,   0, {32'h0000_0001, 64'h0}, 1, 32'h7FFF_FFFF);
    add_row(PREC_32, RND_EVEN,   0, {32'h8000_0000, 64'h0}, 1, 32'h8000_0000);
    add_row(PREC_32, RND_EVEN,   0, {32'hFFFF_FFFE, 64'h1}, 1, 32'h8000_0000);
    add_row(PREC_32, RND_EVEN,   0, {32'h0, 64'h0000_0000_7FFF_FFFF}, 1, 32'h7FFF_FFFF);
    add_row(PREC_32, RND_EVEN,   0, {32'h0, 64'h8000_0000_0000_0000}, 1, 32'h8000_0000);
    add_row(PREC_32, RND_EVEN,   0, {32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF}, 1, 32'hFFFF_FFFF);
    add_row(PREC_32, RND_EVEN,   0, {32'hFFFF_FFFF, 64'h0}, 1, 32'h0000_0000);
    add_row(PREC_32, RND_PINF,  33, {32'h0, 64'h0000_0001_0000_0001});
    add_row(PREC_32, RND_NINF,  63, {32'hFFFF_FFFF, 64'h8000_0000_0000_0001});

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    bursty = 1'b1;
    foreach (stim_rows[k]) begin
      if (stim_rows[k].prec != cur_prec || stim_rows[k].rnd != cur_rnd ||
          stim_rows[k].shift != cur_shift) begin
        settle_pipe();
        program_regs(stim_rows[k].prec, stim_rows[k].rnd, stim_rows[k].shift);
      end
      push_acc(stim_rows[k].acc,
               stim_rows[k].known ? stim_rows[k].word : requant_word(stim_rows[k].acc));
    end
    n_directed = n_sent;

    // Random phases. The first four pin the register extremes. The sixth
    // phase has the long hold-off on the receiver, so that the pipeline fills
    // and stops taking input.
    phase = 0;
    while (n_sent < TOTAL_ITEMS) begin
      case (phase)
        0:       begin p = PREC_4;  r = RND_NINF; sh = 7'(63);  end
        1:       begin p = PREC_32; r = RND_EVEN; sh = 7'(-64); end
        2:       begin p = PREC_16; r = RND_ZERO; sh = 7'(-16); end
        3:       begin p = PREC_8;  r = RND_PINF; sh = 7'(1);   end
        default: begin
          p  = prec_t'($urandom_range(0, 3));
          r  = rnd_t'($urandom_range(0, 3));
          sh = pick_shift();
        end
      endcase
      settle_pipe();
      program_regs(p, r, sh);
      bursty = ($urandom_range(0, 3) != 0);
      if (phase == 5)
        hold_req = 1'b1;
      count = $urandom_range(30, 110);
      for (k = 0; k < count && n_sent < TOTAL_ITEMS; k++) begin
        acc = gen_acc();
        push_acc(acc, requant_word(acc));
      end
      phase++;
    end

    settle_pipe();
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    $display("Sent %0d accumulator words (%0d hand-picked) over %0d register settings.",
             n_sent, n_directed, n_settings);
    $display("Checked %0d packed words, receiver held off %0d time(s), %0d mismatch(es).",
             n_checked, n_holds, n_errs);
    if (n_errs == 0 && pending_words.size() == 0)
      $display("** simd_requantize_pack_top: PASSED **");
    else
      $display("** simd_requantize_pack_top: FAILED **");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rqp_pkg.sv
sv/rqp_split.sv
sv/rqp_shift.sv
sv/rqp_round.sv
sv/rqp_pack.sv
sv/simd_requantize_pack_top.sv
sv/rqp_checker.sv
sim/tb_simd_requantize_pack_top.sv
